// File: hw/rtl/angle_bias_kalman_filter_core_macros.svh
// ----------------------------------------------------------------------------
// angle bias kalman filter core - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH

// consequent in the cycle after the antecedent, quiet during reset
`define ABKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abkf: next-cycle check failed");

// consequent in the same cycle, quiet during reset
`define ABKF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abkf: same-cycle check failed");

// checked through reset as well
`define ABKF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("abkf: reset check failed");

`endif

// File: hw/rtl/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// types, register codes and the micro-program of the angle/bias filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abkf_pkg;

  localparam int DATA_W    = 32;
  localparam int NOISE_W   = 31;
  localparam int DT_W      = 21;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 3;
  localparam int SRC_W     = 5;
  localparam int PC_W      = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] accel_angle;
    logic signed [DATA_W-1:0] gyro_rate;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle_out;
    logic signed [DATA_W-1:0] rate_out;
  } out_t;

  typedef struct packed {
    logic [NOISE_W-1:0] angle_noise;
    logic [NOISE_W-1:0] bias_noise;
    logic [NOISE_W-1:0] meas_noise;
    logic [DT_W-1:0]    time_step;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd3;

  // register reset codes (unsigned Q11.20, time step Q1.20)
  localparam logic [NOISE_W-1:0] RST_ANGLE_NOISE = 31'd1049;
  localparam logic [NOISE_W-1:0] RST_BIAS_NOISE  = 31'd3146;
  localparam logic [NOISE_W-1:0] RST_MEAS_NOISE  = 31'd524288;
  localparam logic [DT_W-1:0]    RST_TIME_STEP   = 21'd5243;

  // micro-op codes
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_END = 3'd4;

  // operand / destination codes
  localparam logic [SRC_W-1:0] R_ZERO  = 5'd0;
  localparam logic [SRC_W-1:0] R_ANGLE = 5'd1;
  localparam logic [SRC_W-1:0] R_BIAS  = 5'd2;
  localparam logic [SRC_W-1:0] R_CAA   = 5'd3;
  localparam logic [SRC_W-1:0] R_CAB   = 5'd4;
  localparam logic [SRC_W-1:0] R_CBA   = 5'd5;
  localparam logic [SRC_W-1:0] R_CBB   = 5'd6;
  localparam logic [SRC_W-1:0] R_GYRO  = 5'd7;
  localparam logic [SRC_W-1:0] R_ACCEL = 5'd8;
  localparam logic [SRC_W-1:0] R_DT    = 5'd9;
  localparam logic [SRC_W-1:0] R_QA    = 5'd10;
  localparam logic [SRC_W-1:0] R_QB    = 5'd11;
  localparam logic [SRC_W-1:0] R_MEAS  = 5'd12;
  localparam logic [SRC_W-1:0] R_TMP   = 5'd13;
  localparam logic [SRC_W-1:0] R_MRES  = 5'd14;
  localparam logic [SRC_W-1:0] R_ERR   = 5'd15;
  localparam logic [SRC_W-1:0] R_INNOV = 5'd16;
  localparam logic [SRC_W-1:0] R_K0    = 5'd17;
  localparam logic [SRC_W-1:0] R_K1    = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SRC_W-1:0] src_a;
    logic [SRC_W-1:0] src_b;
    logic [SRC_W-1:0] dst;
  } uop_t;

  function automatic uop_t mk_uop(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] a,
                                  input logic [SRC_W-1:0] b, input logic [SRC_W-1:0] d);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    return u;
  endfunction

  // one filter update; old covariance terms are consumed before they are overwritten
  function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk_uop(OP_SUB, R_GYRO,  R_BIAS,  R_TMP);
      5'd1:  u = mk_uop(OP_MUL, R_TMP,   R_DT,    R_MRES);
      5'd2:  u = mk_uop(OP_ADD, R_ANGLE, R_MRES,  R_ANGLE);
      5'd3:  u = mk_uop(OP_SUB, R_QA,    R_CAB,   R_TMP);
      5'd4:  u = mk_uop(OP_SUB, R_TMP,   R_CBA,   R_TMP);
      5'd5:  u = mk_uop(OP_MUL, R_TMP,   R_DT,    R_MRES);
      5'd6:  u = mk_uop(OP_ADD, R_CAA,   R_MRES,  R_CAA);
      5'd7:  u = mk_uop(OP_SUB, R_ZERO,  R_CBB,   R_TMP);
      5'd8:  u = mk_uop(OP_MUL, R_TMP,   R_DT,    R_MRES);
      5'd9:  u = mk_uop(OP_ADD, R_CAB,   R_MRES,  R_CAB);
      5'd10: u = mk_uop(OP_ADD, R_CBA,   R_MRES,  R_CBA);
      5'd11: u = mk_uop(OP_MUL, R_QB,    R_DT,    R_MRES);
      5'd12: u = mk_uop(OP_ADD, R_CBB,   R_MRES,  R_CBB);
      5'd13: u = mk_uop(OP_SUB, R_ACCEL, R_ANGLE, R_ERR);
      5'd14: u = mk_uop(OP_ADD, R_MEAS,  R_CAA,   R_INNOV);
      5'd15: u = mk_uop(OP_DIV, R_CAA,   R_INNOV, R_K0);
      5'd16: u = mk_uop(OP_DIV, R_CBA,   R_INNOV, R_K1);
      5'd17: u = mk_uop(OP_MUL, R_K1,    R_CAA,   R_MRES);
      5'd18: u = mk_uop(OP_SUB, R_CBA,   R_MRES,  R_CBA);
      5'd19: u = mk_uop(OP_MUL, R_K1,    R_CAB,   R_MRES);
      5'd20: u = mk_uop(OP_SUB, R_CBB,   R_MRES,  R_CBB);
      5'd21: u = mk_uop(OP_MUL, R_K0,    R_CAB,   R_MRES);
      5'd22: u = mk_uop(OP_SUB, R_CAB,   R_MRES,  R_CAB);
      5'd23: u = mk_uop(OP_MUL, R_K0,    R_CAA,   R_MRES);
      5'd24: u = mk_uop(OP_SUB, R_CAA,   R_MRES,  R_CAA);
      5'd25: u = mk_uop(OP_MUL, R_K0,    R_ERR,   R_MRES);
      5'd26: u = mk_uop(OP_ADD, R_ANGLE, R_MRES,  R_ANGLE);
      5'd27: u = mk_uop(OP_MUL, R_K1,    R_ERR,   R_MRES);
      5'd28: u = mk_uop(OP_ADD, R_BIAS,  R_MRES,  R_BIAS);
      5'd29: u = mk_uop(OP_SUB, R_GYRO,  R_BIAS,  R_TMP);
      default: u = mk_uop(OP_END, R_ZERO, R_ZERO, R_ZERO);
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/abkf_mul.sv
// ----------------------------------------------------------------------------
// abkf_mul
// two-stage signed fixed-point multiplier, round half up and saturate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abkf_mul #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [abkf_pkg::DATA_W-1:0]  a,
  input  logic signed [abkf_pkg::DATA_W-1:0]  b,
  output logic                                done,
  output logic signed [abkf_pkg::DATA_W-1:0]  res
);
  import abkf_pkg::*;

  localparam logic signed [63:0] ROUND   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  logic signed [63:0]       prod;
  logic signed [63:0]       prod_r;
  logic signed [63:0]       rnd;
  logic signed [63:0]       shd;
  logic signed [DATA_W-1:0] sat_val;
  logic signed [DATA_W-1:0] res_r;
  logic                     v1_r;
  logic                     v2_r;

  assign prod = a * b;

  // floor of the rounded product, then clamp
  always_comb begin
    rnd = prod_r + ROUND;
    shd = rnd >>> FRAC_BITS;
    if (shd > S32_MAX) begin
      sat_val = 32'sh7fff_ffff;
    end else if (shd < S32_MIN) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = shd[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    res_r  <= sat_val;
  end

  assign done = v2_r;
  assign res  = res_r;

endmodule

// File: hw/rtl/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// fixed-point divider (n << FRAC_BITS) / d, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abkf_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [abkf_pkg::DATA_W-1:0]  num,
  input  logic signed [abkf_pkg::DATA_W-1:0]  den,
  output logic                                done,
  output logic signed [abkf_pkg::DATA_W-1:0]  res
);
  import abkf_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_PREP = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_FIN  = 2'd3;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [4:0]               cnt_r;
  logic [4:0]               cnt_nxt;
  logic                     done_r;
  logic                     done_nxt;
  logic signed [DATA_W-1:0] n_r;
  logic signed [DATA_W-1:0] d_r;
  logic                     sign_r;
  logic [DATA_W-1:0]        dmag_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        rem_nxt;
  logic [DATA_W-1:0]        q_r;
  logic [DATA_W-1:0]        q_nxt;
  logic signed [DATA_W-1:0] res_r;
  logic signed [DATA_W-1:0] res_nxt;

  logic [DATA_W-1:0]        nmag;
  logic [DATA_W-1:0]        dmag;
  logic [63:0]              lhs;
  logic [63:0]              rhs;
  logic                     sign;
  logic [DATA_W:0]          rem_sh;
  logic [DATA_W:0]          rem_sub;
  logic                     ge;

  always_comb begin
    nmag    = n_r[DATA_W-1] ? (~n_r + 1'b1) : n_r;
    dmag    = d_r[DATA_W-1] ? (~d_r + 1'b1) : d_r;
    sign    = n_r[DATA_W-1] ^ d_r[DATA_W-1];
    // quotient reaches 2^31 exactly when (|n| << F) >= (|d| << 31)
    lhs     = {32'd0, nmag} << FRAC_BITS;
    rhs     = {32'd0, dmag} << 31;
    rem_sh  = {rem_r, q_r[DATA_W-1]};
    rem_sub = rem_sh - {1'b0, dmag_r};
    ge      = rem_sh >= {1'b0, dmag_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_PREP;
        end
      end
      D_PREP: begin
        cnt_nxt = '0;
        if (dmag == '0) begin
          res_nxt   = '0;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else if (lhs >= rhs) begin
          res_nxt   = sign ? 32'sh8000_0000 : 32'sh7fff_ffff;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          // top bits of the dividend are already below the divisor
          rem_nxt   = nmag >> (DATA_W - FRAC_BITS);
          q_nxt     = nmag << FRAC_BITS;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        res_nxt   = sign_r ? $signed(~q_r + 1'b1) : $signed(q_r);
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      n_r <= num;
      d_r <= den;
    end
    if (state_r == D_PREP) begin
      sign_r <= sign;
      dmag_r <= dmag;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: hw/rtl/abkf_seq.sv
// ----------------------------------------------------------------------------
// abkf_seq
// micro-sequencer, filter state registers and the shared saturating adder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abkf_seq #(
  parameter int FRAC_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  abkf_pkg::in_t         in_item,
  input  abkf_pkg::cfg_t        cfg,
  input  logic                  res_ready,
  output abkf_pkg::seq_stat_t   stat,
  output abkf_pkg::out_t        result
);
  import abkf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [PC_W-1:0]          pc_r;
  logic [PC_W-1:0]          pc_nxt;

  logic signed [DATA_W-1:0] angle_r;
  logic signed [DATA_W-1:0] bias_r;
  logic signed [DATA_W-1:0] caa_r;
  logic signed [DATA_W-1:0] cab_r;
  logic signed [DATA_W-1:0] cba_r;
  logic signed [DATA_W-1:0] cbb_r;
  logic signed [DATA_W-1:0] gyro_r;
  logic signed [DATA_W-1:0] accel_r;
  logic signed [DATA_W-1:0] tmp_r;
  logic signed [DATA_W-1:0] mres_r;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] innov_r;
  logic signed [DATA_W-1:0] k0_r;
  logic signed [DATA_W-1:0] k1_r;

  uop_t                     uop;
  logic signed [DATA_W-1:0] opa;
  logic signed [DATA_W-1:0] opb;
  logic [DATA_W:0]          sum_w;
  logic signed [DATA_W-1:0] alu_res;
  logic                     wb_en;
  logic signed [DATA_W-1:0] wb_val;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [DATA_W-1:0] mul_res;
  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_res;
  logic                     out_done;

  function automatic logic signed [DATA_W-1:0] pick(input logic [SRC_W-1:0] code);
    logic signed [DATA_W-1:0] v;
    case (code)
      R_ANGLE: v = angle_r;
      R_BIAS:  v = bias_r;
      R_CAA:   v = caa_r;
      R_CAB:   v = cab_r;
      R_CBA:   v = cba_r;
      R_CBB:   v = cbb_r;
      R_GYRO:  v = gyro_r;
      R_ACCEL: v = accel_r;
      R_DT:    v = $signed({11'd0, cfg.time_step});
      R_QA:    v = $signed({1'b0, cfg.angle_noise});
      R_QB:    v = $signed({1'b0, cfg.bias_noise});
      R_MEAS:  v = $signed({1'b0, cfg.meas_noise});
      R_TMP:   v = tmp_r;
      R_MRES:  v = mres_r;
      R_ERR:   v = err_r;
      R_INNOV: v = innov_r;
      R_K0:    v = k0_r;
      R_K1:    v = k1_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop = prog_rom(pc_r);
  assign opa = pick(uop.src_a);
  assign opb = pick(uop.src_b);

  // 33-bit sum, clamped back to 32 bits
  always_comb begin
    if (uop.op == OP_SUB) begin
      sum_w = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
    end else begin
      sum_w = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
    end
    if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
      alu_res = sum_w[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      alu_res = $signed(sum_w[DATA_W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    wb_en     = 1'b0;
    wb_val    = alu_res;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_done  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          pc_nxt    = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (uop.op)
          OP_ADD, OP_SUB: begin
            wb_en  = 1'b1;
            pc_nxt = pc_r + 1'b1;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = ST_WAIT;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = ST_WAIT;
          end
          OP_END: begin
            // hold the finished item until the output register is free
            if (res_ready) begin
              out_done  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_WAIT: begin
        if (uop.op == OP_MUL && mul_done) begin
          wb_en     = 1'b1;
          wb_val    = mul_res;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_ISSUE;
        end else if (uop.op == OP_DIV && div_done) begin
          wb_en     = 1'b1;
          wb_val    = div_res;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      caa_r   <= ONE;
      cab_r   <= '0;
      cba_r   <= '0;
      cbb_r   <= ONE;
    end else if (wb_en) begin
      case (uop.dst)
        R_ANGLE: angle_r <= wb_val;
        R_BIAS:  bias_r  <= wb_val;
        R_CAA:   caa_r   <= wb_val;
        R_CAB:   cab_r   <= wb_val;
        R_CBA:   cba_r   <= wb_val;
        R_CBB:   cbb_r   <= wb_val;
        default: ;
      endcase
    end
  end

  // per-request scratch
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      gyro_r  <= in_item.gyro_rate;
      accel_r <= in_item.accel_angle;
    end
    if (wb_en) begin
      case (uop.dst)
        R_TMP:   tmp_r   <= wb_val;
        R_MRES:  mres_r  <= wb_val;
        R_ERR:   err_r   <= wb_val;
        R_INNOV: innov_r <= wb_val;
        R_K0:    k0_r    <= wb_val;
        R_K1:    k1_r    <= wb_val;
        default: ;
      endcase
    end
  end

  abkf_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .res   (mul_res)
  );

  abkf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .res   (div_res)
  );

  assign stat.busy       = (state_r != ST_IDLE);
  assign stat.done       = out_done;
  assign result.angle_out = angle_r;
  assign result.rate_out  = tmp_r;

endmodule

// File: hw/rtl/angle_bias_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// two-state angle / gyro-bias kalman filter, signed fixed point
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one request per sample (accelerometer angle, gyro rate). a request
//           is taken on a clock edge with in_valid high and in_stall low.
//   out_* : one result per request (filtered angle, bias-corrected rate),
//           held in an output register until taken with out_stall low.
//   cfg_* : noise and sample period registers, written by the user only while
//           idle; the core leaves the check to the user.
// work: each request runs two gain divisions (32 quotient steps each), ten
//   multiplies and eighteen adds on the shared units; a gain division with
//   a zero innovation variance or a saturating quotient skips its steps.
// flow: one request in flight; in_stall stays high until its result
//   is moved into the output register, so the next request waits for it.
// stall: a stalled result blocks the next one from leaving the sequencer,
//   which holds in_stall high meanwhile.
// reset: registers return to their default codes, the estimates to zero and
//   the covariance to the identity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module angle_bias_kalman_filter_core #(
  parameter int FRAC_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  abkf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output abkf_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [abkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abkf_pkg::NOISE_W-1:0]       cfg_wdata
);
  import abkf_pkg::*;

  cfg_t      cfg_r;
  seq_stat_t stat;
  out_t      seq_res;
  out_t      out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      res_ready;
  logic      in_take;

  assign in_take   = in_valid && !stat.busy;
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_noise <= RST_ANGLE_NOISE;
      cfg_r.bias_noise  <= RST_BIAS_NOISE;
      cfg_r.meas_noise  <= RST_MEAS_NOISE;
      cfg_r.time_step   <= RST_TIME_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_NOISE: cfg_r.angle_noise <= cfg_wdata;
        CFG_BIAS_NOISE:  cfg_r.bias_noise  <= cfg_wdata;
        CFG_MEAS_NOISE:  cfg_r.meas_noise  <= cfg_wdata;
        CFG_TIME_STEP:   cfg_r.time_step   <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r <= seq_res;
    end
  end

  abkf_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_take),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .stat      (stat),
    .result    (seq_res)
  );

  assign in_stall  = stat.busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/abkf_checker.sv
// ----------------------------------------------------------------------------
// abkf_checker
// port-level checks on the filter core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "angle_bias_kalman_filter_core_macros.svh"

module abkf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input abkf_pkg::out_t out_data
);
  import abkf_pkg::*;

  // a taken request keeps the input side closed while it is worked on
  `ABKF_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

  // a fresh result only appears out of a busy sequencer
  `ABKF_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))

  // a stalled result is held unchanged
  `ABKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // reset empties both sides
  `ABKF_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && !in_stall)

endmodule

bind angle_bias_kalman_filter_core abkf_checker u_abkf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_angle_bias_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// tb_angle_bias_kalman_filter_core
// self-checking bench for the angle / gyro-bias kalman filter core. a short
// table of directed samples and register settings runs first, then random
// phases with fresh noise and sample-period settings. every result is
// compared with a fixed-point model of the filter kept inside the bench, or
// with the value in its table row, under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter_core;
  import abkf_pkg::*;

  localparam int     FRAC           = 20;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -64'sd2147483648;
  localparam int     PHASES         = 12;
  localparam int     PHASE_SAMPLES  = 140;
  localparam int     HOLD_CYCLES    = 500;
  localparam int     TAIL_CYCLES    = 130;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ANGLE_SPAN     = 94371840;   // 90 degrees
  localparam int     RATE_SPAN      = 262144000;  // 250 degrees per second

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e kind;
    reg_idx_t  idx;
    logic [NOISE_W-1:0] value;
    in_t       sample;
    bit        fixed;
    out_t      fixed_res;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = CFG_ANGLE_NOISE;
  logic [NOISE_W-1:0] cfg_wdata = '0;

  // filter model: registers and state
  longint q_angle   = longint'(RST_ANGLE_NOISE);
  longint q_bias    = longint'(RST_BIAS_NOISE);
  longint r_meas    = longint'(RST_MEAS_NOISE);
  longint dt_step   = longint'(RST_TIME_STEP);
  longint est_angle = 0;
  longint est_bias  = 0;
  longint p_aa      = longint'(1) << FRAC;
  longint p_ab      = 0;
  longint p_ba      = 0;
  longint p_bb      = longint'(1) << FRAC;

  out_t expected_estimates[$];
  stim_row_t plan[$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  angle_bias_kalman_filter_core #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return sat32(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return sat32(a - b);
  endfunction

  // exact product, rounded half up
  function automatic longint fx_mul(input longint a, input longint b);
    longint y;
    y = a * b + (longint'(1) << (FRAC - 1));
    return sat32(y >>> FRAC);
  endfunction

  // quotient truncated toward zero, zero divisor gives a zero gain
  function automatic longint fx_div(input longint n, input longint d);
    if (d == 0) return 0;
    return sat32((n * (longint'(1) << FRAC)) / d);
  endfunction

  // one predict / gain / correct pass over the model state
  function automatic out_t filter_update(input in_t s);
    longint accel, gyro, d_aa, d_off, err, innov, k0, k1, t0, t1, rate;
    out_t r;
    accel = longint'($signed(s.accel_angle));
    gyro  = longint'($signed(s.gyro_rate));

    est_angle = fx_add(est_angle, fx_mul(fx_sub(gyro, est_bias), dt_step));
    d_aa  = fx_sub(fx_sub(q_angle, p_ab), p_ba);
    d_off = fx_sub(0, p_bb);
    p_aa  = fx_add(p_aa, fx_mul(d_aa, dt_step));
    p_ab  = fx_add(p_ab, fx_mul(d_off, dt_step));
    p_ba  = fx_add(p_ba, fx_mul(d_off, dt_step));
    p_bb  = fx_add(p_bb, fx_mul(q_bias, dt_step));

    err   = fx_sub(accel, est_angle);
    innov = fx_add(r_meas, p_aa);
    k0    = fx_div(p_aa, innov);
    k1    = fx_div(p_ba, innov);
    t0    = p_aa;
    t1    = p_ab;

    p_aa  = fx_sub(p_aa, fx_mul(k0, t0));
    p_ab  = fx_sub(p_ab, fx_mul(k0, t1));
    p_ba  = fx_sub(p_ba, fx_mul(k1, t0));
    p_bb  = fx_sub(p_bb, fx_mul(k1, t1));
    est_angle = fx_add(est_angle, fx_mul(k0, err));
    est_bias  = fx_add(est_bias, fx_mul(k1, err));
    rate      = fx_sub(gyro, est_bias);

    r.angle_out = est_angle[31:0];
    r.rate_out  = rate[31:0];
    return r;
  endfunction

  function automatic stim_row_t sample_row(input logic [31:0] a, input logic [31:0] g);
    stim_row_t row;
    row.kind      = ROW_SAMPLE;
    row.idx       = CFG_ANGLE_NOISE;
    row.value     = '0;
    row.sample    = {a, g};
    row.fixed     = 1'b0;
    row.fixed_res = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [31:0] a, input logic [31:0] g,
                                          input logic [31:0] ea, input logic [31:0] er);
    stim_row_t row;
    row = sample_row(a, g);
    row.fixed     = 1'b1;
    row.fixed_res = {ea, er};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input reg_idx_t idx, input logic [NOISE_W-1:0] v);
    stim_row_t row;
    row = sample_row('0, '0);
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.value = v;
    return row;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(60, 250);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic in_t random_sample();
    in_t s;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      s.accel_angle = $urandom_range(0, 2 * ANGLE_SPAN) - ANGLE_SPAN;
      s.gyro_rate   = $urandom_range(0, 2 * RATE_SPAN) - RATE_SPAN;
    end else if (r < 85) begin
      s.accel_angle = $urandom;
      s.gyro_rate   = $urandom;
    end else if (r < 92) begin
      s.accel_angle = corner_value();
      s.gyro_rate   = corner_value();
    end else begin
      s.accel_angle = $urandom_range(0, 131072) - 65536;
      s.gyro_rate   = $urandom_range(0, 131072) - 65536;
    end
    return s;
  endfunction

  function automatic logic [NOISE_W-1:0] pick_reg_value(input reg_idx_t idx);
    logic [NOISE_W-1:0] full;
    int r;
    full = NOISE_W'($urandom);
    r = $urandom_range(0, 9);
    case (idx)
      CFG_TIME_STEP: begin
        case (r)
          0:       return '0;
          1:       return 31'd1;
          2:       return 31'(RST_TIME_STEP);
          3:       return 31'd1048576;
          4:       return 31'h1f_ffff;
          5:       return full;  // upper bits fall away
          default: return NOISE_W'($urandom_range(1, 1048576));
        endcase
      end
      default: begin
        case (r)
          0:       return (idx == CFG_MEAS_NOISE) ? 31'd1 : '0;
          1:       return 31'h7fff_ffff;
          2, 3:    return (idx == CFG_ANGLE_NOISE) ? RST_ANGLE_NOISE :
                          (idx == CFG_BIAS_NOISE)  ? RST_BIAS_NOISE : RST_MEAS_NOISE;
          4, 5, 6: return NOISE_W'($urandom_range(0, 1048576));
          default: return full;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %0s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [NOISE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_ANGLE_NOISE: q_angle = longint'(v);
      CFG_BIAS_NOISE:  q_bias  = longint'(v);
      CFG_MEAS_NOISE:  r_meas  = longint'(v);
      CFG_TIME_STEP:   dt_step = longint'(v[DT_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // gap_needed leaves in_valid low afterwards so the caller can drain
  task automatic send_sample(input in_t s, input bit gap_needed, input bit fixed,
                             input out_t fixed_res);
    int   gap;
    out_t predicted;
    cfg_we   <= 1'b0;
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = filter_update(s);
    expected_estimates.push_back(fixed ? fixed_res : predicted);
    gap = pick_gap();
    if (gap_needed && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_estimates.size() != 0) @(posedge clk);
  endtask

  // result side: check, then choose the next stall
  initial begin : result_side
    int   busy_left, free_left, hold_left;
    out_t want;
    busy_left = 0;
    free_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending, angle %0d rate %0d", $realtime,
                     $signed(out_data.angle_out), $signed(out_data.rate_out));
        end else begin
          want = expected_estimates.pop_front();
          if (out_data.angle_out !== want.angle_out)
            report_mismatch("angle_out", want.angle_out, out_data.angle_out);
          if (out_data.rate_out !== want.rate_out)
            report_mismatch("rate_out", want.rate_out, out_data.rate_out);
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (busy_left > 0) begin
        busy_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        busy_left = pick_gap();
        free_left = calm ? 0 : $urandom_range(0, 40);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("angle_bias_kalman_filter_core verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit gap_needed;
    bit drain_here;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // from reset, zero inputs leave both estimates at zero
    plan.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0));
    plan.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0));
    plan.push_back(sample_row(32'h7fff_ffff, 32'h7fff_ffff));
    plan.push_back(sample_row(32'h8000_0000, 32'h8000_0000));
    plan.push_back(sample_row(32'h7fff_ffff, 32'h8000_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h7fff_ffff));
    plan.push_back(sample_row(32'hffff_ffff, 32'h0000_0001));
    plan.push_back(reg_row(CFG_TIME_STEP, 31'd1048576));
    plan.push_back(sample_row(32'h8000_0000, 32'h7fff_ffff));
    plan.push_back(sample_row(32'd12345, -32'sd6789));
    // no measurement noise and no time step: the second sample sees a zero
    // innovation variance and keeps the predicted state
    plan.push_back(reg_row(CFG_TIME_STEP, '0));
    plan.push_back(reg_row(CFG_MEAS_NOISE, '0));
    plan.push_back(sample_row(32'd100, 32'd200));
    plan.push_back(sample_row(32'd300, -32'sd400));
    plan.push_back(sample_row(-32'sd5, 32'd7));
    plan.push_back(reg_row(CFG_ANGLE_NOISE, 31'h7fff_ffff));
    plan.push_back(reg_row(CFG_BIAS_NOISE, 31'h7fff_ffff));
    plan.push_back(reg_row(CFG_MEAS_NOISE, 31'h7fff_ffff));
    plan.push_back(reg_row(CFG_TIME_STEP, 31'h1f_ffff));
    plan.push_back(sample_row(32'h7fff_ffff, 32'h8000_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h8000_0000));
    plan.push_back(reg_row(CFG_ANGLE_NOISE, '0));
    plan.push_back(reg_row(CFG_BIAS_NOISE, '0));
    plan.push_back(reg_row(CFG_MEAS_NOISE, 31'd1));
    plan.push_back(reg_row(CFG_TIME_STEP, 31'd1));
    plan.push_back(sample_row(32'h0010_0000, -32'sh0010_0000));
    plan.push_back(sample_row(32'h1234_5678, 32'h0765_4321));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        gap_needed = (i + 1 == plan.size()) || (plan[i + 1].kind == ROW_REG);
        send_sample(plan[i].sample, gap_needed, plan[i].fixed, plan[i].fixed_res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        write_reg(CFG_ANGLE_NOISE, RST_ANGLE_NOISE);
        write_reg(CFG_BIAS_NOISE, RST_BIAS_NOISE);
        write_reg(CFG_MEAS_NOISE, RST_MEAS_NOISE);
        write_reg(CFG_TIME_STEP, 31'(RST_TIME_STEP));
      end else begin
        write_reg(CFG_ANGLE_NOISE, pick_reg_value(CFG_ANGLE_NOISE));
        write_reg(CFG_BIAS_NOISE, pick_reg_value(CFG_BIAS_NOISE));
        write_reg(CFG_MEAS_NOISE, pick_reg_value(CFG_MEAS_NOISE));
        write_reg(CFG_TIME_STEP, pick_reg_value(CFG_TIME_STEP));
      end
      calm = (ph == 3);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // long result-side hold while requests keep coming
        if (ph == 5 && n == 20) hold_req = 1'b1;
        drain_here = (ph == 7 && n == 59);
        send_sample(random_sample(), drain_here || n == PHASE_SAMPLES - 1, 1'b0, '0);
        if (drain_here) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_estimates.size() == 0)
      $display("angle_bias_kalman_filter_core verification clean");
    else
      $display("angle_bias_kalman_filter_core verification failed");
    $finish;
  end

endmodule
